FILE: src/bdc_pkg.sv
// shared constants and types of the b-dot detumble controller
package bdc_pkg;

    localparam int FIELD_W   = 16;
    localparam int DIFF_W    = FIELD_W + 1;
    localparam int DIP_W     = 16;
    localparam int GAIN_W    = 16;
    localparam int ROW_W     = 48;
    localparam int RATE_W    = 16;
    localparam int OP_W      = 18;
    localparam int ACC_W     = 51;
    localparam int NUM_W     = 42;
    localparam int QUO_W     = 17;
    localparam int REM_W     = 19;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 48;
    localparam int HALF_SHIFT = 17;

    localparam logic [RATE_W-1:0] DEFAULT_RATE = RATE_W'(10);

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_ROW0    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_ROW1    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_ROW2    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIPOLE_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_RATE  = 3'd4;

    // operation of the shared compare-subtract unit
    typedef enum logic {
        ITER_SQRT = 1'b0,
        ITER_DIV  = 1'b1
    } t_iter_mode;

    typedef struct packed {
        logic       start;
        t_iter_mode mode;
    } t_iter_cmd;

endpackage

FILE: src/bdc_mul.sv
// shared registered 18x18 signed multiplier with optional half-word shift
module bdc_mul (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_en,
    input  logic                               i_shift,
    input  logic signed [bdc_pkg::OP_W-1:0]    i_a,
    input  logic signed [bdc_pkg::OP_W-1:0]    i_b,
    output logic                               o_valid,
    output logic signed [bdc_pkg::ACC_W-1:0]   o_p
);

    logic signed [2*bdc_pkg::OP_W-1:0] w_prod;
    logic signed [bdc_pkg::ACC_W-1:0]  w_ext;
    logic                              r_valid;
    logic signed [bdc_pkg::ACC_W-1:0]  r_p;

    assign w_prod = i_a * i_b;
    assign w_ext  = bdc_pkg::ACC_W'(w_prod);

    // valid flag follows the issue strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_en;
        end
    end

    // product register
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= i_shift ? (w_ext <<< bdc_pkg::HALF_SHIFT) : w_ext;
        end
    end

    assign o_valid = r_valid;
    assign o_p     = r_p;

endmodule

FILE: src/bdc_iter.sv
// iterative compare-subtract unit for the square root and the quotient
module bdc_iter (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  bdc_pkg::t_iter_cmd              i_cmd,
    input  logic [bdc_pkg::NUM_W-1:0]       i_num,
    input  logic [15:0]                     i_den,
    output logic                            o_busy,
    output logic                            o_done,
    output logic [bdc_pkg::QUO_W-1:0]       o_res
);

    logic                             r_busy;
    logic                             r_done;
    bdc_pkg::t_iter_mode              r_mode;
    logic [4:0]                       r_cnt;
    logic [bdc_pkg::REM_W-1:0]        r_rem;
    logic [bdc_pkg::QUO_W-1:0]        r_res;
    logic [31:0]                      r_sh;
    logic [15:0]                      r_den;
    logic [bdc_pkg::REM_W-1:0]        w_cand;
    logic [bdc_pkg::REM_W-1:0]        w_trial;
    logic                             w_ge;

    // candidate remainder and trial value of one step
    always_comb begin
        if (r_mode == bdc_pkg::ITER_SQRT) begin
            w_cand  = {r_rem[16:0], r_sh[31:30]};
            w_trial = {1'b0, r_res[15:0], 2'b01};
        end else begin
            w_cand  = {1'b0, r_rem[16:0], r_sh[31]};
            w_trial = {3'b000, r_den};
        end
    end

    assign w_ge = (w_cand >= w_trial);

    // control: busy, step count, done strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_cmd.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= (i_cmd.mode == bdc_pkg::ITER_SQRT) ? 5'd15 : 5'd16;
            end else if (r_busy) begin
                if (r_cnt == 5'd0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 5'd1;
                end
            end
        end
    end

    // datapath: load and one digit per cycle
    always_ff @(posedge i_clk) begin
        if (i_cmd.start && !r_busy) begin
            r_mode <= i_cmd.mode;
            r_den  <= i_den;
            r_res  <= '0;
            if (i_cmd.mode == bdc_pkg::ITER_SQRT) begin
                r_rem <= '0;
                r_sh  <= i_num[31:0];
            end else begin
                r_rem <= {3'b000, i_num[32:17]};
                r_sh  <= {i_num[16:0], 15'b0};
            end
        end else if (r_busy) begin
            r_rem <= w_ge ? (w_cand - w_trial) : w_cand;
            r_res <= {r_res[15:0], w_ge};
            r_sh  <= (r_mode == bdc_pkg::ITER_SQRT) ? (r_sh << 2) : (r_sh << 1);
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_res  = r_res;

endmodule

FILE: src/bdot_detumble_controller_top.sv
// top level: sequencer, registers, accumulation and clamp of the b-dot controller
// load: a load request presents its result in the cycle after acceptance
// control step: the field norm squares, then the square root, then per axis the gain
//   products and the rate products in the shared multiplier and, unless the quotient
//   overflows, the division in the shared compare-subtract unit, then the clamp
// throughput: one sample at a time; the next is taken once the result is taken
// reset: synchronous active low; clears configuration registers, previous field and control
module bdot_detumble_controller_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  logic                                 i_func,
    input  logic signed [bdc_pkg::FIELD_W-1:0]   i_field_x,
    input  logic signed [bdc_pkg::FIELD_W-1:0]   i_field_y,
    input  logic signed [bdc_pkg::FIELD_W-1:0]   i_field_z,
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output logic signed [bdc_pkg::DIP_W-1:0]     o_dipole_x,
    output logic signed [bdc_pkg::DIP_W-1:0]     o_dipole_y,
    output logic signed [bdc_pkg::DIP_W-1:0]     o_dipole_z,
    output logic [2:0]                           o_clamp_mask,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [bdc_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [bdc_pkg::CFG_W-1:0]            i_cfg_data
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SQ    = 7'b0000010,
        S_SQRT  = 7'b0000100,
        S_AX    = 7'b0001000,
        S_RATE  = 7'b0010000,
        S_DIV   = 7'b0100000,
        S_OUT   = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    logic [bdc_pkg::ROW_W-1:0]               r_gain [3];
    logic [bdc_pkg::CFG_W-1:0]               r_limit;
    logic [bdc_pkg::RATE_W-1:0]              r_rate;
    logic signed [bdc_pkg::FIELD_W-1:0]      r_prev [3];
    logic signed [bdc_pkg::FIELD_W-1:0]      r_b [3];
    logic signed [bdc_pkg::DIFF_W-1:0]       r_d [3];
    logic signed [bdc_pkg::ACC_W-1:0]        r_acc;
    logic [1:0]                              r_k;
    logic [1:0]                              r_axis;
    logic [15:0]                             r_n;
    logic                                    r_neg;
    logic [33:0]                             r_mag;
    logic                                    r_big;
    logic [bdc_pkg::QUO_W-1:0]               r_q;
    logic                                    r_clamp_go;
    logic signed [bdc_pkg::DIP_W-1:0]        r_dip [3];
    logic [2:0]                              r_mask;

    logic                                    w_in_acc;
    logic                                    w_out_acc;
    logic [bdc_pkg::RATE_W-1:0]              w_rate;
    logic                                    w_mul_en;
    logic                                    w_mul_shift;
    logic signed [bdc_pkg::OP_W-1:0]         w_mul_a;
    logic signed [bdc_pkg::OP_W-1:0]         w_mul_b;
    logic                                    w_mul_valid;
    logic signed [bdc_pkg::ACC_W-1:0]        w_mul_p;
    logic signed [bdc_pkg::ACC_W-1:0]        n_acc;
    bdc_pkg::t_iter_cmd                      w_cmd;
    logic [bdc_pkg::NUM_W-1:0]               w_num;
    logic [15:0]                             w_den;
    logic                                    w_it_busy;
    logic                                    w_it_done;
    logic [bdc_pkg::QUO_W-1:0]               w_it_res;
    logic [bdc_pkg::NUM_W-1:0]               w_den_hi;
    logic                                    w_over;
    logic [bdc_pkg::GAIN_W-1:0]              w_gain;
    logic [15:0]                             w_lim;
    logic [15:0]                             w_q1;
    logic [15:0]                             w_q2;
    logic                                    w_cl;
    logic signed [bdc_pkg::DIP_W-1:0]        w_dip;
    logic signed [bdc_pkg::ACC_W-1:0]        w_s;
    logic [bdc_pkg::ACC_W-1:0]               w_abs;

    function automatic logic [bdc_pkg::ACC_W-1:0] ACC_NEG(
        input logic signed [bdc_pkg::ACC_W-1:0] v
    );
        ACC_NEG = -v;
    endfunction

    assign w_in_acc  = i_in_valid && o_in_ready;
    assign w_out_acc = o_out_valid && i_out_ready;
    assign w_rate    = (r_rate == '0) ? bdc_pkg::DEFAULT_RATE : r_rate;

    // configuration registers
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain[0] <= '0;
            r_gain[1] <= '0;
            r_gain[2] <= '0;
            r_limit   <= '0;
            r_rate    <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                bdc_pkg::REG_GAIN_ROW0:    r_gain[0] <= i_cfg_data;
                bdc_pkg::REG_GAIN_ROW1:    r_gain[1] <= i_cfg_data;
                bdc_pkg::REG_GAIN_ROW2:    r_gain[2] <= i_cfg_data;
                bdc_pkg::REG_DIPOLE_LIMIT: r_limit   <= i_cfg_data;
                bdc_pkg::REG_SAMPLE_RATE:  r_rate    <= i_cfg_data[bdc_pkg::RATE_W-1:0];
                default: ;
            endcase
        end
    end

    // multiplier operand selection
    assign w_gain = r_gain[r_axis][16*r_k +: 16];
    always_comb begin
        w_mul_en    = 1'b0;
        w_mul_shift = 1'b0;
        w_mul_a     = '0;
        w_mul_b     = '0;
        if (r_state == S_SQ && r_k != 2'd3) begin
            w_mul_en = 1'b1;
            w_mul_a  = bdc_pkg::OP_W'(r_prev[r_k]);
            w_mul_b  = bdc_pkg::OP_W'(r_prev[r_k]);
        end else if (r_state == S_AX && r_k != 2'd3) begin
            w_mul_en = 1'b1;
            w_mul_a  = bdc_pkg::OP_W'($signed(w_gain));
            w_mul_b  = bdc_pkg::OP_W'(r_d[r_k]);
        end else if (r_state == S_RATE && r_k < 2'd2) begin
            w_mul_en    = 1'b1;
            w_mul_shift = (r_k == 2'd1);
            w_mul_a     = (r_k == 2'd1) ? $signed({1'b0, r_mag[33:17]})
                                        : $signed({1'b0, r_mag[16:0]});
            w_mul_b     = $signed({2'b00, w_rate});
        end
    end

    bdc_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_mul_en),
        .i_shift (w_mul_shift),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_valid (w_mul_valid),
        .o_p     (w_mul_p)
    );

    // running sum of products
    assign n_acc = w_mul_valid ? (r_acc + w_mul_p) : r_acc;
    assign w_s   = n_acc;
    assign w_abs = (w_s < 0) ? ACC_NEG(w_s) : w_s;

    // root operand is the full sum of squares, quotient operand drops the q8.8 fraction
    assign w_den    = (r_n == '0) ? 16'd1 : r_n;
    assign w_num    = (r_state == S_SQ) ? bdc_pkg::NUM_W'(n_acc[31:0])
                                        : n_acc[bdc_pkg::NUM_W+7:8];
    assign w_den_hi = {9'b0, w_den, 17'b0};
    assign w_over   = (w_num >= w_den_hi);
    always_comb begin
        w_cmd.start = 1'b0;
        w_cmd.mode  = bdc_pkg::ITER_SQRT;
        if (r_state == S_SQ && r_k == 2'd3) begin
            w_cmd.start = 1'b1;
        end else if (r_state == S_RATE && r_k == 2'd2 && !w_over) begin
            w_cmd.start = 1'b1;
            w_cmd.mode  = bdc_pkg::ITER_DIV;
        end
    end

    bdc_iter u_iter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_busy  (w_it_busy),
        .o_done  (w_it_done),
        .o_res   (w_it_res)
    );

    // limit clamp, then the signed output range
    assign w_lim = r_limit[16*r_axis +: 16];
    always_comb begin
        w_cl = 1'b0;
        if (r_big || r_q > {1'b0, w_lim}) begin
            w_q1 = w_lim;
            w_cl = 1'b1;
        end else begin
            w_q1 = r_q[15:0];
        end
        w_q2 = w_q1;
        if (r_neg && w_q1 > 16'd32768) begin
            w_q2 = 16'd32768;
            w_cl = 1'b1;
        end else if (!r_neg && w_q1 > 16'd32767) begin
            w_q2 = 16'd32767;
            w_cl = 1'b1;
        end
        w_dip = r_neg ? $signed(16'd0 - w_q2) : $signed(w_q2);
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_in_acc) n_state = i_func ? S_OUT : S_SQ;
            S_SQ:   if (r_k == 2'd3) n_state = S_SQRT;
            S_SQRT: if (w_it_done) n_state = S_AX;
            S_AX:   if (r_k == 2'd3) n_state = S_RATE;
            S_RATE: if (r_k == 2'd2) n_state = w_over ? S_DIV : S_DIV;
            S_DIV: begin
                if (r_clamp_go && r_axis == 2'd2) n_state = S_OUT;
                else if (r_clamp_go) n_state = S_AX;
            end
            S_OUT:  if (w_out_acc) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // sequencer datapath
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev[0]  <= '0;
            r_prev[1]  <= '0;
            r_prev[2]  <= '0;
            r_clamp_go <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_b[0] <= i_field_x;
                        r_b[1] <= i_field_y;
                        r_b[2] <= i_field_z;
                        r_d[0] <= bdc_pkg::DIFF_W'(i_field_x) - bdc_pkg::DIFF_W'(r_prev[0]);
                        r_d[1] <= bdc_pkg::DIFF_W'(i_field_y) - bdc_pkg::DIFF_W'(r_prev[1]);
                        r_d[2] <= bdc_pkg::DIFF_W'(i_field_z) - bdc_pkg::DIFF_W'(r_prev[2]);
                        r_acc  <= '0;
                        r_k    <= 2'd0;
                        r_axis <= 2'd0;
                        r_mask <= '0;
                        if (i_func) begin
                            r_prev[0] <= i_field_x;
                            r_prev[1] <= i_field_y;
                            r_prev[2] <= i_field_z;
                            r_dip[0]  <= '0;
                            r_dip[1]  <= '0;
                            r_dip[2]  <= '0;
                        end
                    end
                end
                S_SQ: begin
                    r_acc <= n_acc;
                    r_k   <= r_k + 2'd1;
                end
                S_SQRT: begin
                    if (w_it_done) begin
                        r_n   <= w_it_res[15:0];
                        r_acc <= '0;
                        r_k   <= 2'd0;
                    end
                end
                S_AX: begin
                    if (r_k == 2'd3) begin
                        r_neg <= (w_s > 0);
                        r_mag <= w_abs[33:0];
                        r_acc <= '0;
                        r_k   <= 2'd0;
                    end else begin
                        r_acc <= n_acc;
                        r_k   <= r_k + 2'd1;
                    end
                end
                S_RATE: begin
                    r_acc <= n_acc;
                    r_k   <= r_k + 2'd1;
                    r_big <= w_over;
                    if (r_k == 2'd2) begin
                        r_clamp_go <= w_over;
                        r_q        <= '0;
                    end
                end
                S_DIV: begin
                    if (r_clamp_go) begin
                        r_clamp_go     <= 1'b0;
                        r_dip[r_axis]  <= w_dip;
                        r_mask[r_axis] <= w_cl;
                        r_acc          <= '0;
                        r_k            <= 2'd0;
                        r_axis         <= r_axis + 2'd1;
                        if (r_axis == 2'd2) begin
                            r_prev[0] <= r_b[0];
                            r_prev[1] <= r_b[1];
                            r_prev[2] <= r_b[2];
                        end
                    end else if (w_it_done) begin
                        r_q        <= w_it_res;
                        r_clamp_go <= 1'b1;
                    end
                end
                S_OUT: ;
                default: ;
            endcase
        end
    end

    assign o_in_ready   = (r_state == S_IDLE);
    assign o_out_valid  = (r_state == S_OUT);
    assign o_dipole_x   = r_dip[0];
    assign o_dipole_y   = r_dip[1];
    assign o_dipole_z   = r_dip[2];
    assign o_clamp_mask = r_mask;

`ifndef SYNTHESIS
    // a sample is never taken while a result is pending
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_in_ready && o_out_valid))
        else $error("input ready while result pending");

    // the shared unit only runs in the root and quotient phases
    a_iter_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_it_busy |-> (r_state == S_SQRT || r_state == S_DIV))
        else $error("iterative unit busy outside its phases");

    // a load request returns zero dipole and an empty mask
    a_load_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_func) |=> (o_out_valid && o_clamp_mask == 3'b000
                                  && o_dipole_x == 0 && o_dipole_y == 0
                                  && o_dipole_z == 0))
        else $error("load request gave nonzero result");
`endif

endmodule
